FILE: sv/pat_pkg.sv
// pat_pkg: shared types, codes and defaults for the page alias table.
// Used by pat_entry_check and page_alias_table; depends on nothing.
`timescale 1ns / 1ps

package pat_pkg;

  // Default table geometry
  localparam int CELLS_DEF   = 256;
  localparam int ALIASES_DEF = 8;

  localparam int OWNER_W = 16;
  localparam int ADDR_W  = 32;

  // Command codes
  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_ALIAS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_CELL   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_SLOT   = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;

  // One slot word; the backed bit has meaning only in slot 0 of a cell
  typedef struct packed {
    logic               backed;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  // Match results for one slot word
  typedef struct packed {
    logic hit;       // owner and address equal the key
    logic free;      // owner and address both zero
    logic no_owner;  // owner zero
    logic backed;    // backed bit of the word
  } flags_t;

endpackage

FILE: sv/pat_entry_check.sv
// pat_entry_check: compares one slot word against the lookup key.
// Depends on pat_pkg for the entry and flag types.
`timescale 1ns / 1ps

module pat_entry_check (
  input  pat_pkg::entry_t                   entry,
  input  logic [pat_pkg::OWNER_W-1:0]       key_owner,
  input  logic [pat_pkg::ADDR_W-1:0]        key_addr,
  output pat_pkg::flags_t                   flags
);

  logic owner_zero;
  logic addr_zero;

  // Decode the word
  assign owner_zero     = (entry.owner == '0);
  assign addr_zero      = (entry.addr == '0);
  assign flags.hit      = (entry.owner == key_owner) && (entry.addr == key_addr);
  assign flags.free     = owner_zero && addr_zero;
  assign flags.no_owner = owner_zero;
  assign flags.backed   = entry.backed;

endmodule

FILE: sv/page_alias_table.sv
// page_alias_table: top level with the slot memory and the command sequencer.
// Depends on pat_pkg and pat_entry_check.
`timescale 1ns / 1ps

// Page alias table. All state sits in one slot memory of CELLS*ALIASES words
// (owner, address, and the cell's backed bit kept in the slot 0 word), read
// through one registered port and written through one port. After reset a
// clearing pass writes every word, during which no request is taken. A get
// reads the slot 0 word of one cell per cycle; alias and release read one
// slot per cycle. Only one request is in work at a time; a finished response
// sits in the output register while the next request is taken.
module page_alias_table #(
  parameter int CELLS   = pat_pkg::CELLS_DEF,
  parameter int ALIASES = pat_pkg::ALIASES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  command,
  input  logic [pat_pkg::OWNER_W-1:0] owner_id,
  input  logic [pat_pkg::ADDR_W-1:0]  address,
  input  logic [pat_pkg::OWNER_W-1:0] dest_owner,
  input  logic [pat_pkg::ADDR_W-1:0]  dest_address,
  input  logic                        backing_ok,
  input  logic                        grant_ok,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [2:0]                  status,
  output logic [pat_pkg::ADDR_W-1:0]  result_address,
  output logic [7:0]                  frame_index,
  output logic [2:0]                  slot_index
);

  localparam int DEPTH = CELLS * ALIASES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CELLS);
  localparam int SW    = $clog2(ALIASES);

  localparam logic [AW:0]   GET_STEP  = (AW+1)'(ALIASES);
  localparam logic [AW:0]   RD_LIMIT  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] CELL_STEP = AW'(ALIASES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(ALIASES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GET,
    S_LOOK,
    S_FREE,
    S_DONE
  } state_t;

  state_t state;

  // Slot memory and its ports
  pat_pkg::entry_t mem [DEPTH];
  pat_pkg::entry_t mem_rdata;
  pat_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_waddr;
  logic            mem_we;

  // Scan pointers: rd_addr runs one read ahead of the word being checked
  logic [AW:0]     rd_addr;
  logic [AW-1:0]   chk_addr;
  logic [CW-1:0]   chk_cell;
  logic [SW-1:0]   chk_slot;
  logic            primed;
  logic [AW-1:0]   clr_addr;
  logic [SW-1:0]   src_slot;

  // Held request
  logic [1:0]                  cmd_q;
  logic [pat_pkg::OWNER_W-1:0] own_q;
  logic [pat_pkg::ADDR_W-1:0]  addr_q;
  logic [pat_pkg::OWNER_W-1:0] downer_q;
  logic [pat_pkg::ADDR_W-1:0]  daddr_q;
  logic                        back_ok_q;
  logic                        grant_ok_q;

  // Finished result waiting for the output register
  logic [2:0]                  res_status;
  logic [pat_pkg::ADDR_W-1:0]  res_addr;
  logic [CW-1:0]               res_cell;
  logic [SW-1:0]               res_slot;

  pat_pkg::flags_t flags;

  // Compare the returning word against the held key
  pat_entry_check u_check (
    .entry     (mem_rdata),
    .key_owner (own_q),
    .key_addr  (addr_q),
    .flags     (flags)
  );

  // Memory write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_addr < RD_LIMIT) begin
      mem_rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  assign req_ready = (state == S_IDLE);

  // Sequencer: clear, scan, write back, hand over the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      mem_we    <= 1'b0;
      rsp_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      // Raise the response when the done state loads it, drop it after the transfer
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          mem_we    <= 1'b1;
          mem_waddr <= clr_addr;
          mem_wdata <= '0;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end

        S_IDLE: begin
          mem_we <= 1'b0;
          if (req_valid) begin
            cmd_q      <= command;
            own_q      <= owner_id;
            addr_q     <= address;
            downer_q   <= dest_owner;
            daddr_q    <= dest_address;
            back_ok_q  <= backing_ok;
            grant_ok_q <= grant_ok;
            rd_addr    <= '0;
            chk_addr   <= '0;
            chk_cell   <= '0;
            chk_slot   <= '0;
            primed     <= 1'b0;
            res_addr   <= '0;
            res_cell   <= '0;
            res_slot   <= '0;
            case (command)
              pat_pkg::CMD_GET:     state <= S_GET;
              pat_pkg::CMD_ALIAS:   state <= S_LOOK;
              pat_pkg::CMD_RELEASE: state <= S_LOOK;
              default: begin
                res_status <= pat_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // Walk slot 0 of each cell for the lowest one without an owner
        S_GET: begin
          rd_addr <= rd_addr + GET_STEP;
          primed  <= 1'b1;
          if (primed) begin
            chk_cell <= chk_cell + 1'b1;
            chk_addr <= chk_addr + CELL_STEP;
            if (flags.no_owner) begin
              state    <= S_DONE;
              res_cell <= chk_cell;
              res_slot <= '0;
              if (!flags.backed && !back_ok_q) begin
                res_status <= pat_pkg::ST_NO_CELL;
              end else begin
                mem_we           <= 1'b1;
                mem_waddr        <= chk_addr;
                mem_wdata.backed <= 1'b1;
                if (grant_ok_q) begin
                  mem_wdata.owner <= own_q;
                  mem_wdata.addr  <= addr_q;
                  res_status      <= pat_pkg::ST_OK;
                  res_addr        <= addr_q;
                end else begin
                  mem_wdata.owner <= '0;
                  mem_wdata.addr  <= '0;
                  res_status      <= pat_pkg::ST_REFUSED;
                end
              end
            end else if (chk_cell == LAST_CELL) begin
              state      <= S_DONE;
              res_status <= pat_pkg::ST_NO_CELL;
            end
          end
        end

        // Walk the slots of backed cells, up to the first unbacked cell, for the owner and address
        S_LOOK: begin
          rd_addr <= rd_addr + 1'b1;
          primed  <= 1'b1;
          if (primed) begin
            chk_addr <= chk_addr + 1'b1;
            if (chk_slot == LAST_SLOT) begin
              chk_slot <= '0;
              chk_cell <= chk_cell + 1'b1;
            end else begin
              chk_slot <= chk_slot + 1'b1;
            end
            if (chk_slot == '0 && !flags.backed) begin
              state      <= S_DONE;
              res_status <= pat_pkg::ST_NOT_FOUND;
            end else if (flags.hit) begin
              if (cmd_q == pat_pkg::CMD_RELEASE) begin
                mem_we           <= 1'b1;
                mem_waddr        <= chk_addr;
                mem_wdata.backed <= (chk_slot == '0);
                mem_wdata.owner  <= '0;
                mem_wdata.addr   <= '0;
                res_status       <= pat_pkg::ST_OK;
                res_cell         <= chk_cell;
                res_slot         <= chk_slot;
                state            <= S_DONE;
              end else if (chk_slot == LAST_SLOT) begin
                res_status <= pat_pkg::ST_NO_SLOT;
                res_cell   <= chk_cell;
                res_slot   <= chk_slot;
                state      <= S_DONE;
              end else begin
                src_slot <= chk_slot;
                state    <= S_FREE;
              end
            end else if (chk_cell == LAST_CELL && chk_slot == LAST_SLOT) begin
              state      <= S_DONE;
              res_status <= pat_pkg::ST_NOT_FOUND;
            end
          end
        end

        // Continue in the same cell for the first free slot
        S_FREE: begin
          rd_addr  <= rd_addr + 1'b1;
          chk_addr <= chk_addr + 1'b1;
          chk_slot <= chk_slot + 1'b1;
          if (flags.free) begin
            res_cell <= chk_cell;
            res_slot <= chk_slot;
            state    <= S_DONE;
            if (grant_ok_q) begin
              mem_we           <= 1'b1;
              mem_waddr        <= chk_addr;
              mem_wdata.backed <= 1'b0;
              mem_wdata.owner  <= downer_q;
              mem_wdata.addr   <= daddr_q;
              res_status       <= pat_pkg::ST_OK;
              res_addr         <= daddr_q;
            end else begin
              res_status <= pat_pkg::ST_REFUSED;
            end
          end else if (chk_slot == LAST_SLOT) begin
            res_status <= pat_pkg::ST_NO_SLOT;
            res_cell   <= chk_cell;
            res_slot   <= src_slot;
            state      <= S_DONE;
          end
        end

        // Hand the result to the output register once it is free
        S_DONE: begin
          mem_we <= 1'b0;
          if (!rsp_valid || rsp_ready) begin
            status         <= res_status;
            result_address <= res_addr;
            frame_index    <= 8'(res_cell);
            slot_index     <= 3'(res_slot);
            state          <= S_IDLE;
          end
        end

        default: begin
          mem_we <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  // A command writes back at most one word
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |=> !mem_we)
    else $error("more than one write back for one command");

  // Every error response carries a zero address
  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != pat_pkg::ST_OK) |-> (result_address == '0))
    else $error("error response with nonzero address");

  // Write backs keep the backed bit only in slot 0
  a_backed_bit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_DONE) |-> (mem_wdata.backed == (res_slot == '0)))
    else $error("backed bit written to wrong slot");

  // A response only comes out of the done state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("response raised outside the done state");

endmodule
